// ===== hdl/lzc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzc_pkg
// Shared constants, dictionary entry and table port types for the LZW
// compressor.
// ----------------------------------------------------------------------------
package lzc_pkg;

  localparam int CODE_BITS   = 12;
  localparam int LIT_CODES   = 256;
  localparam int HASH_BITS   = CODE_BITS + 1;
  localparam int TABLE_DEPTH = 1 << HASH_BITS;

  typedef struct packed {
    logic                 used;
    logic [CODE_BITS-1:0] prefix;
    logic [7:0]           data_val;
    logic [CODE_BITS-1:0] code;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                 rd_en;
    logic [HASH_BITS-1:0] rd_addr;
    logic [CODE_BITS-1:0] key_prefix;
    logic [7:0]           key_data;
    logic                 wr_en;
    logic [HASH_BITS-1:0] wr_addr;
    entry_t               wr_entry;
  } table_req_t;

  typedef struct packed {
    logic                 used;
    logic                 hit;
    logic [CODE_BITS-1:0] code;
  } table_rsp_t;

  function automatic logic [HASH_BITS-1:0] hash_key(input logic [CODE_BITS-1:0] p,
                                                    input logic [7:0] d);
    return HASH_BITS'(p) ^ (HASH_BITS'(d) << (HASH_BITS - 8));
  endfunction

endpackage

// ===== hdl/lzc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzc_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lzc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/lzc_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzc_table
// Open-addressed hash table of dictionary entries; compares the stored key
// of each probed slot against the key of the pending lookup.
// ----------------------------------------------------------------------------
module lzc_table (
  input  logic                clk,
  input  lzc_pkg::table_req_t req,
  output lzc_pkg::table_rsp_t rsp
);
  import lzc_pkg::*;

  logic [ENTRY_W-1:0]   rd_word;
  entry_t               rd_entry;
  logic [CODE_BITS-1:0] key_prefix;
  logic [7:0]           key_data;

  lzc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .waddr(req.wr_addr),
    .wdata(req.wr_entry),
    .re   (req.rd_en),
    .raddr(req.rd_addr),
    .rdata(rd_word)
  );

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      key_prefix <= req.key_prefix;
      key_data   <= req.key_data;
    end
  end

  assign rd_entry = entry_t'(rd_word);
  assign rsp.used = rd_entry.used;
  assign rsp.hit  = rd_entry.used && (rd_entry.prefix == key_prefix) &&
                    (rd_entry.data_val == key_data);
  assign rsp.code = rd_entry.code;

endmodule

// ===== hdl/lzc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzc_ctrl
// Sequencer for the compressor: table clearing, probing, insertion and the
// output code register.
// ----------------------------------------------------------------------------
module lzc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_stream,
  input  logic                          byte_valid,
  output logic                          byte_stall,
  output logic [lzc_pkg::CODE_BITS-1:0] code,
  output logic                          final_code,
  output logic                          code_valid,
  input  logic                          code_stall,
  output lzc_pkg::table_req_t           req,
  input  lzc_pkg::table_rsp_t           rsp
);
  import lzc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  state_t               state;
  logic [HASH_BITS-1:0] clr_addr;
  logic [HASH_BITS-1:0] probe_addr;
  logic [HASH_BITS-1:0] probe_step;
  logic [HASH_BITS-1:0] start_addr;
  logic [CODE_BITS-1:0] prefix_code;
  logic                 prefix_valid;
  logic [CODE_BITS:0]   next_code;
  logic [7:0]           data_r;
  logic                 last_r;
  logic                 full;
  logic                 slot_free;

  assign byte_stall = (state != ST_IDLE);
  assign full       = next_code[CODE_BITS];
  assign slot_free  = !code_valid || !code_stall;
  assign probe_step = probe_addr + HASH_BITS'(1);
  assign start_addr = hash_key(prefix_code, data_byte);

  always_comb begin
    req = '0;
    case (state)
      ST_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = clr_addr;
      end
      ST_IDLE: begin
        req.rd_en      = byte_valid && prefix_valid;
        req.rd_addr    = start_addr;
        req.key_prefix = prefix_code;
        req.key_data   = data_byte;
      end
      ST_LOOK: begin
        req.rd_en                 = rsp.used && !rsp.hit;
        req.rd_addr               = probe_step;
        req.key_prefix            = prefix_code;
        req.key_data              = data_r;
        req.wr_en                 = !rsp.used && !full;
        req.wr_addr               = probe_addr;
        req.wr_entry.used         = 1'b1;
        req.wr_entry.prefix       = prefix_code;
        req.wr_entry.data_val     = data_r;
        req.wr_entry.code         = next_code[CODE_BITS-1:0];
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      prefix_code  <= '0;
      prefix_valid <= 1'b0;
      next_code    <= (CODE_BITS + 1)'(LIT_CODES);
      code_valid   <= 1'b0;
    end else begin
      if (code_valid && !code_stall && !(state inside {ST_EMIT, ST_FLUSH})) begin
        code_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + HASH_BITS'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (byte_valid) begin
            data_r <= data_byte;
            last_r <= end_of_stream;
            if (prefix_valid) begin
              probe_addr <= start_addr;
              state      <= ST_LOOK;
            end else begin
              prefix_code  <= CODE_BITS'(data_byte);
              prefix_valid <= 1'b1;
              if (end_of_stream) begin
                state <= ST_FLUSH;
              end
            end
          end
        end
        ST_LOOK: begin
          if (rsp.hit) begin
            prefix_code <= rsp.code;
            state       <= last_r ? ST_FLUSH : ST_IDLE;
          end else if (rsp.used) begin
            probe_addr <= probe_step;
          end else begin
            if (!full) begin
              next_code <= next_code + (CODE_BITS + 1)'(1);
            end
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            code_valid  <= 1'b1;
            code        <= prefix_code;
            final_code  <= 1'b0;
            prefix_code <= CODE_BITS'(data_r);
            state       <= last_r ? ST_FLUSH : ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (slot_free) begin
            code_valid   <= 1'b1;
            code         <= prefix_code;
            final_code   <= 1'b1;
            prefix_code  <= '0;
            prefix_valid <= 1'b0;
            next_code    <= (CODE_BITS + 1)'(LIT_CODES);
            clr_addr     <= '0;
            state        <= ST_CLEAR;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== hdl/lzw_compressor.sv =====
`timescale 1ns / 1ps
// The first byte of a stream only becomes the prefix; a later byte is looked up in the table,
// and a miss also emits a code. Each hash collision in the table adds a read, and a stalled
// output word holds a miss or a flush until it leaves. A new byte is not taken until the last
// one is through; the table RAM has a single read port. A final byte is followed by a flush.
// Reset, and every end of stream, starts a clearing pass over all 2^(CODE_BITS+1) entries
// (8192 at 12-bit codes) of the table, during which no byte is accepted.
// ----------------------------------------------------------------------------
// lzw_compressor
// Byte-in LZW compressor with fixed-width codes and a hashed dictionary.
// ----------------------------------------------------------------------------
module lzw_compressor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_stream,
  output logic                          code_valid,
  input  logic                          code_stall,
  output logic [lzc_pkg::CODE_BITS-1:0] code,
  output logic                          final_code
);
  import lzc_pkg::*;

  table_req_t req;
  table_rsp_t rsp;

  lzc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .code         (code),
    .final_code   (final_code),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .req          (req),
    .rsp          (rsp)
  );

  lzc_table u_table (
    .clk(clk),
    .req(req),
    .rsp(rsp)
  );

endmodule

// ===== hdl/lzc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzc_checker
// Port-level checks for the LZW compressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          byte_valid,
  input logic                          byte_stall,
  input logic                          end_of_stream,
  input logic                          code_valid,
  input logic                          code_stall,
  input logic [lzc_pkg::CODE_BITS-1:0] code,
  input logic                          final_code
);
  import lzc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> code_valid && $stable(code) && $stable(final_code))
    else $error("stalled code word changed");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && end_of_stream |=> byte_stall)
    else $error("byte accepted right after the end of a stream");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(code_valid) && final_code |-> byte_stall)
    else $error("byte accepted while the dictionary is being cleared");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !code_valid)
    else $error("code word presented right after reset");

endmodule

bind lzw_compressor lzc_checker u_checker (.*);
